### src/mips_subset_executor_assert.svh
// assertion macros used by the checker file
`ifndef MIPS_SUBSET_EXECUTOR_ASSERT_SVH
`define MIPS_SUBSET_EXECUTOR_ASSERT_SVH

// implication checked only out of reset
`define MSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbl failed");

// implication checked in the next cycle, during reset too
`define MSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

### src/mse_pkg.sv
// shared types, constants and helpers of the mips subset executor
`default_nettype none
package mse_pkg;

  localparam int DATA_BYTES = 4096;
  localparam int DA_W       = $clog2(DATA_BYTES);
  localparam int REG_COUNT  = 32;
  localparam int RA_W       = $clog2(REG_COUNT);

  localparam logic [31:0] WIN_BASE    = 32'h0000_2000;
  localparam logic [31:0] TEXT_LIMIT  = 32'h0000_0fff;
  localparam logic [31:0] GP_RESET    = 32'h0000_1800;
  localparam logic [31:0] SP_RESET    = 32'h0000_3ffc;
  localparam logic [12:0] PEND_RESET  = 13'd4096;
  localparam logic [31:0] FLOOR_RESET = 32'h0000_3000;

  localparam logic [RA_W-1:0] GP_IDX = RA_W'(28);
  localparam logic [RA_W-1:0] SP_IDX = RA_W'(29);
  localparam logic [RA_W-1:0] LR_IDX = RA_W'(31);

  // item kinds
  localparam logic [1:0] K_EXEC    = 2'd0;
  localparam logic [1:0] K_PRELOAD = 2'd1;
  localparam logic [1:0] K_READ    = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FUNCT  = 3'd1;
  localparam logic [2:0] ST_ADDR   = 3'd2;
  localparam logic [2:0] ST_STACK  = 3'd3;
  localparam logic [2:0] ST_HALT   = 3'd4;

  // configuration register indexes
  localparam logic REG_PEND  = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  // opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // funct codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] instr_word;
    logic [11:0] mem_offset;
    logic [7:0]  load_byte;
    logic [4:0]  reg_select;
  } item_t;

  // queue entry: item plus its class from the front end
  typedef struct packed {
    item_t item;
    logic  is_exec;
  } qent_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_MEM   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  function automatic logic [31:0] reg_reset_val(input logic [RA_W-1:0] idx);
    logic [31:0] v;
    v = 32'h0;
    if (idx == GP_IDX) v = GP_RESET;
    if (idx == SP_IDX) v = SP_RESET;
    return v;
  endfunction

  // r0 reads zero, unwritten entries read their reset value
  function automatic logic [31:0] reg_fix(input logic [RA_W-1:0] idx, input logic vld,
                                          input logic [31:0] q);
    logic [31:0] v;
    v = vld ? q : reg_reset_val(idx);
    if (idx == '0) v = 32'h0;
    return v;
  endfunction

endpackage
`default_nettype wire

### src/mse_ram.sv
// generic single write, single read ram with registered read
`default_nettype none
module mse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/mse_front.sv
// front end: accepts items, tags them and holds them in a two-entry queue
`default_nettype none
module mse_front
  import mse_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  output logic       head_valid,
  output qent_t      head,
  input  wire logic  pop
);
  qent_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  qent_t      ent_in;

  always_comb begin
    ent_in.item    = push_item;
    ent_in.is_exec = (push_item.kind == K_EXEC);
  end

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= ent_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### src/mse_back.sv
// back end: register file, data store, divider and the execution sequencer
`default_nettype none
module mse_back
  import mse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire qent_t       q_head,
  output logic             q_pop,
  input  wire logic [12:0] program_end,
  input  wire logic [31:0] stack_floor,
  output logic             clearing,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_next_pc,
  output logic [31:0]      out_read_value
);
  state_t state_r, state_nxt;
  qent_t  ent_r, ent_nxt;
  logic [31:0] rs_r, rs_nxt, rt_r, rt_nxt;
  logic [31:0] pc_r, pc_nxt, hi_r, hi_nxt, lo_r, lo_nxt, sp_r, sp_nxt;
  logic        stopped_r, stopped_nxt;
  logic [REG_COUNT-1:0] rvld_r, rvld_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] readv_r, readv_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [DA_W-1:0] addr_r, addr_nxt;
  logic [2:0]  size_r, size_nxt;
  logic        is_load_r, is_load_nxt;
  logic [31:0] ldw_r, ldw_nxt;
  logic [31:0] q_r, q_nxt, rem_r, rem_nxt, mt_r, mt_nxt;
  logic        ns_r, ns_nxt, nq_r, nq_nxt;
  logic [DA_W:0] clr_r, clr_nxt;
  logic        ov_r;
  logic [2:0]  os_r;
  logic [31:0] opc_r, orv_r;

  logic            rf_we;
  logic [RA_W-1:0] rf_waddr, rf_ra, rf_rb;
  logic [31:0]     rf_wdata, rf_qa, rf_qb;
  logic            d_we;
  logic [DA_W-1:0] d_waddr, d_raddr;
  logic [7:0]      d_wdata, d_q;

  mse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata), .raddr(rf_ra), .rdata(rf_qa));
  mse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata), .raddr(rf_rb), .rdata(rf_qb));
  mse_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dmem (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_q));

  // decoded fields of the current word
  logic [5:0]  op, fn;
  logic [RA_W-1:0] rsn, rtn, rdn;
  logic [4:0]  sh;
  logic [31:0] simm, zimm, pc4, eaddr, jtgt, btgt, rdv;
  logic [33:0] woff;
  logic [2:0]  msize;
  logic        rd_we;
  logic [RA_W-1:0] rd_idx;
  logic [63:0] prod;
  logic [32:0] rem_sh, diff;
  logic [31:0] ld_full, ldv;
  logic [7:0]  stb;

  always_comb begin
    op    = ent_r.item.instr_word[31:26];
    fn    = ent_r.item.instr_word[5:0];
    rsn   = ent_r.item.instr_word[25:21];
    rtn   = ent_r.item.instr_word[20:16];
    rdn   = ent_r.item.instr_word[15:11];
    sh    = ent_r.item.instr_word[10:6];
    simm  = {{16{ent_r.item.instr_word[15]}}, ent_r.item.instr_word[15:0]};
    zimm  = {16'h0, ent_r.item.instr_word[15:0]};
    pc4   = pc_r + 32'd4;
    eaddr = rs_r + simm;
    jtgt  = {pc4[31:28], ent_r.item.instr_word[25:0], 2'b00};
    btgt  = pc4 + {simm[29:0], 2'b00};
    woff  = {2'b00, eaddr} - {2'b00, WIN_BASE};
    prod  = $signed(rs_r) * $signed(rt_r);
    case (op)
      OP_LB, OP_SB: msize = 3'd1;
      OP_LH, OP_SH: msize = 3'd2;
      OP_LW, OP_SW: msize = 3'd4;
      default:      msize = 3'd0;
    endcase
    rem_sh = {rem_r, q_r[31]};
    diff   = rem_sh - {1'b0, mt_r};
    ld_full = ldw_r | ({24'h0, d_q} << {(cnt_r[1:0] - 2'd1), 3'b000});
    case (size_r)
      3'd1:    ldv = {{24{ld_full[7]}}, ld_full[7:0]};
      3'd2:    ldv = {{16{ld_full[15]}}, ld_full[15:0]};
      default: ldv = ld_full;
    endcase
    stb = 8'(rt_r >> {cnt_r[1:0], 3'b000});
  end

  always_comb begin
    state_nxt = state_r;  ent_nxt = ent_r;  rs_nxt = rs_r;  rt_nxt = rt_r;
    pc_nxt = pc_r;  hi_nxt = hi_r;  lo_nxt = lo_r;  sp_nxt = sp_r;
    stopped_nxt = stopped_r;  rvld_nxt = rvld_r;  status_nxt = status_r;
    readv_nxt = readv_r;  cnt_nxt = cnt_r;  addr_nxt = addr_r;  size_nxt = size_r;
    is_load_nxt = is_load_r;  ldw_nxt = ldw_r;  q_nxt = q_r;  rem_nxt = rem_r;
    mt_nxt = mt_r;  ns_nxt = ns_r;  nq_nxt = nq_r;  clr_nxt = clr_r;
    q_pop = 1'b0;
    rf_ra = q_head.is_exec ? q_head.item.instr_word[25:21] : q_head.item.reg_select;
    rf_rb = q_head.item.instr_word[20:16];
    d_we = 1'b0;  d_waddr = '0;  d_wdata = 8'h0;  d_raddr = '0;
    rd_we = 1'b0;  rd_idx = rdn;  rdv = 32'h0;

    case (state_r)
      S_CLEAR: begin
        d_we    = 1'b1;
        d_waddr = clr_r[DA_W-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (DA_W+1)'(DATA_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ent_nxt   = q_head;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        rs_nxt = reg_fix(ent_r.is_exec ? rsn : ent_r.item.reg_select,
                         rvld_r[ent_r.is_exec ? rsn : ent_r.item.reg_select], rf_qa);
        rt_nxt = reg_fix(rtn, rvld_r[rtn], rf_qb);
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt  = S_FIN;
        readv_nxt  = 32'h0;
        status_nxt = ST_OK;
        if (!ent_r.is_exec) begin
          if (ent_r.item.kind == K_PRELOAD && 32'(ent_r.item.mem_offset) < DATA_BYTES) begin
            d_we    = 1'b1;
            d_waddr = DA_W'(32'(ent_r.item.mem_offset));
            d_wdata = ent_r.item.load_byte;
          end
          if (ent_r.item.kind == K_READ) readv_nxt = rs_r;
          if (stopped_r) status_nxt = ST_HALT;
        end else if (stopped_r) begin
          status_nxt = ST_HALT;
        end else if (pc_r > TEXT_LIMIT || pc_r >= 32'(program_end)) begin
          status_nxt = ST_HALT;  stopped_nxt = 1'b1;
        end else if (sp_r < stack_floor) begin
          status_nxt = ST_STACK;  stopped_nxt = 1'b1;
        end else if (op == OP_SPECIAL) begin
          pc_nxt = pc4;
          case (fn)
            FN_SLL:  begin rd_we = 1'b1; rdv = rt_r << sh; end
            FN_SRL:  begin rd_we = 1'b1; rdv = rt_r >> sh; end
            FN_SRA:  begin rd_we = 1'b1; rdv = 32'($signed(rt_r) >>> sh); end
            FN_JR:   pc_nxt = rs_r;
            FN_MFHI: begin rd_we = 1'b1; rdv = hi_r; end
            FN_MFLO: begin rd_we = 1'b1; rdv = lo_r; end
            FN_MULT: begin hi_nxt = prod[63:32]; lo_nxt = prod[31:0]; end
            FN_DIV: begin
              if (rt_r == 32'h0) begin
                lo_nxt = 32'hffff_ffff;  hi_nxt = rs_r;
              end else begin
                ns_nxt  = rs_r[31];
                nq_nxt  = rs_r[31] ^ rt_r[31];
                q_nxt   = rs_r[31] ? (32'h0 - rs_r) : rs_r;
                mt_nxt  = rt_r[31] ? (32'h0 - rt_r) : rt_r;
                rem_nxt = 32'h0;
                cnt_nxt = 6'd0;
                state_nxt = S_DIV;
              end
            end
            FN_ADD:  begin rd_we = 1'b1; rdv = rs_r + rt_r; end
            FN_SUB:  begin rd_we = 1'b1; rdv = rs_r - rt_r; end
            FN_AND:  begin rd_we = 1'b1; rdv = rs_r & rt_r; end
            FN_OR:   begin rd_we = 1'b1; rdv = rs_r | rt_r; end
            FN_SLT:  begin rd_we = 1'b1; rdv = {31'h0, $signed(rs_r) < $signed(rt_r)}; end
            default: begin
              pc_nxt = pc_r;  status_nxt = ST_FUNCT;  stopped_nxt = 1'b1;
            end
          endcase
        end else if (msize != 3'd0 &&
                     (woff[33] || (woff + 34'(msize)) > 34'(DATA_BYTES))) begin
          status_nxt = ST_ADDR;  stopped_nxt = 1'b1;
        end else begin
          pc_nxt = pc4;
          rd_idx = rtn;
          case (op)
            OP_J:   pc_nxt = jtgt;
            OP_JAL: begin pc_nxt = jtgt; rd_we = 1'b1; rd_idx = LR_IDX; rdv = pc4; end
            OP_BEQ: if (rs_r == rt_r) pc_nxt = btgt;
            OP_BNE: if (rs_r != rt_r) pc_nxt = btgt;
            OP_ADDI, OP_ADDIU: begin rd_we = 1'b1; rdv = eaddr; end
            OP_SLTI: begin rd_we = 1'b1; rdv = {31'h0, $signed(rs_r) < $signed(simm)}; end
            OP_ANDI: begin rd_we = 1'b1; rdv = rs_r & zimm; end
            OP_ORI:  begin rd_we = 1'b1; rdv = rs_r | zimm; end
            OP_LUI:  begin rd_we = 1'b1; rdv = {ent_r.item.instr_word[15:0], 16'h0}; end
            OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW: begin
              addr_nxt    = woff[DA_W-1:0];
              size_nxt    = msize;
              is_load_nxt = (op == OP_LB || op == OP_LH || op == OP_LW);
              ldw_nxt     = 32'h0;
              cnt_nxt     = 6'd0;
              state_nxt   = S_MEM;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (cnt_r == 6'd32) begin
          lo_nxt = nq_r ? (32'h0 - q_r) : q_r;
          hi_nxt = ns_r ? (32'h0 - rem_r) : rem_r;
          state_nxt = S_FIN;
        end else begin
          rem_nxt = diff[32] ? rem_sh[31:0] : diff[31:0];
          q_nxt   = {q_r[30:0], ~diff[32]};
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_MEM: begin
        cnt_nxt = cnt_r + 6'd1;
        if (is_load_r) begin
          d_raddr = addr_r + DA_W'(cnt_r[2:0]);
          if (cnt_r != 6'd0) ldw_nxt = ld_full;
          if (cnt_r == 6'(size_r)) begin
            rd_we = 1'b1;  rd_idx = rtn;  rdv = ldv;
            state_nxt = S_FIN;
          end
        end else begin
          d_we    = 1'b1;
          d_waddr = addr_r + DA_W'(cnt_r[2:0]);
          d_wdata = stb;
          if (cnt_r == 6'(size_r - 3'd1)) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    rf_we    = rd_we;
    rf_waddr = rd_idx;
    rf_wdata = rdv;
    if (rd_we) begin
      rvld_nxt[rd_idx] = 1'b1;
      if (rd_idx == SP_IDX) sp_nxt = rdv;
    end
  end

  assign clearing       = (state_r == S_CLEAR);
  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_next_pc    = opc_r;
  assign out_read_value = orv_r;

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;  rs_r <= rs_nxt;  rt_r <= rt_nxt;
    status_r <= status_nxt;  readv_r <= readv_nxt;
    addr_r <= addr_nxt;  size_r <= size_nxt;  is_load_r <= is_load_nxt;
    ldw_r <= ldw_nxt;  q_r <= q_nxt;  rem_r <= rem_nxt;  mt_r <= mt_nxt;
    ns_r <= ns_nxt;  nq_r <= nq_nxt;  cnt_r <= cnt_nxt;
    if (state_r == S_FIN && (!ov_r || out_ready)) begin
      os_r  <= status_r;
      opc_r <= pc_r;
      orv_r <= readv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      pc_r      <= 32'h0;
      hi_r      <= 32'h0;
      lo_r      <= 32'h0;
      sp_r      <= SP_RESET;
      stopped_r <= 1'b0;
      rvld_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      pc_r      <= pc_nxt;
      hi_r      <= hi_nxt;
      lo_r      <= lo_nxt;
      sp_r      <= sp_nxt;
      stopped_r <= stopped_nxt;
      rvld_r    <= rvld_nxt;
      if (state_r == S_FIN && (!ov_r || out_ready)) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### src/mips_subset_executor.sv
// top level of the mips subset executor: channels, config registers, front and back
//
//  channel  | direction | handshake          | payload
//  in_      | in        | in_valid/in_ready  | kind, instr_word, mem_offset, load_byte, reg_select
//  out_     | out       | out_valid/out_ready| status, next_pc, read_value
//  config   | in        | psel/penable/pwrite| paddr, pwdata, prdata (program_end, stack_floor)
//
// an item passes the back end steps queue pop, register read, execute and output load
// loads and stores step through the byte-wide data ram one byte at a time
// div produces one quotient bit per cycle in the restoring divider
// after reset a clearing pass zeroes the data ram with in_ready low
// the two-entry queue keeps taking items, until full, while the back end works or the output stalls
`default_nettype none
module mips_subset_executor
  import mse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_instr_word,
  input  wire logic [11:0] in_mem_offset,
  input  wire logic [7:0]  in_load_byte,
  input  wire logic [4:0]  in_reg_select,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_next_pc,
  output logic [31:0]      out_read_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [12:0] pend_r;
  logic [31:0] floor_r;
  item_t       in_item;
  logic        q_full, q_valid, q_pop, clearing;
  qent_t       q_head;

  // item fields gathered for the queue
  always_comb begin
    in_item.kind       = in_kind;
    in_item.instr_word = in_instr_word;
    in_item.mem_offset = in_mem_offset;
    in_item.load_byte  = in_load_byte;
    in_item.reg_select = in_reg_select;
  end

  // no transfer while the data ram is being cleared
  assign in_ready = !q_full && !clearing;
  assign pready   = 1'b1;

  // register index is the word address
  assign prdata = (paddr[2] == REG_PEND) ? {19'h0, pend_r} : floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= PEND_RESET;
      floor_r <= FLOOR_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PEND) pend_r <= pwdata[12:0];
      else                      floor_r <= pwdata;
    end
  end

  mse_front u_front (
    .clk(clk), .rst_n(rst_n),
    .push(in_valid && in_ready), .push_item(in_item),
    .full(q_full), .head_valid(q_valid), .head(q_head), .pop(q_pop)
  );

  mse_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .program_end(pend_r), .stack_floor(floor_r), .clearing(clearing),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_next_pc(out_next_pc), .out_read_value(out_read_value)
  );
endmodule
`default_nettype wire

### src/mse_checker.sv
// port-level checker of the mips subset executor and its bind
`default_nettype none
`include "mips_subset_executor_assert.svh"
module mse_checker
  import mse_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_read_value,
  input wire logic        pready
);
  `MSE_ASSERT_NEXT(a_reset_empty, !rst_n, !out_valid)
  `MSE_ASSERT_IMP(a_status_range, out_valid, out_status <= ST_HALT)
  `MSE_ASSERT_IMP(a_err_no_read, out_valid && (out_status == ST_FUNCT || out_status == ST_ADDR || out_status == ST_STACK), out_read_value == 32'h0)
  `MSE_ASSERT_IMP(a_hold, out_valid && !out_ready, ##1 (out_valid && $stable(out_status)))
  `MSE_ASSERT_IMP(a_pready, 1'b1, pready)
endmodule

bind mips_subset_executor mse_checker u_mse_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_status(out_status), .out_read_value(out_read_value), .pready(pready)
);
`default_nettype wire

### dv/tb_top.sv
// self-checking testbench of the mips subset executor
`timescale 1ns / 100ps

module tb_top
  import mse_pkg::*;
;

  // one expected result of an item
  typedef struct {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic [31:0] read_value;
  } outcome_t;

  // tracks processor state and holds the outcomes still owed by the block
  class exec_scoreboard;
    logic [31:0] regs[REG_COUNT];
    logic [31:0] pc, hi, lo;
    logic [7:0]  dmem[DATA_BYTES];
    logic        halted;
    logic [12:0] prog_end;
    logic [31:0] floor;
    outcome_t    owed[$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = 32'h0;
      regs[GP_IDX] = GP_RESET;
      regs[SP_IDX] = SP_RESET;
      foreach (dmem[i]) dmem[i] = 8'h0;
      pc = 0; hi = 0; lo = 0;
      halted = 1'b0;
      prog_end = PEND_RESET;
      floor = FLOOR_RESET;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch on %s: got %h want %h", $realtime, what, got, want);
    endtask

    function void put_reg(logic [4:0] r, logic [31:0] v);
      if (r != 5'd0) regs[r] = v;
    endfunction

    function logic [31:0] mem_get(logic [31:0] addr, int size);
      logic [31:0] v;
      int base;
      v = 0;
      base = int'(addr - WIN_BASE);
      for (int i = 0; i < size; i++) v |= 32'(dmem[base + i]) << (8 * i);
      return v;
    endfunction

    // executes one instruction word, returns its status
    function logic [2:0] run_word(logic [31:0] w);
      logic [5:0]  op, fn;
      logic [4:0]  rsn, rtn, rdn, sh;
      logic [31:0] a, b, simm, zimm, pc4, addr, nxt, ms, mt, q, r, v;
      longint      sa, sb2, p;
      int          size, base;
      op = w[31:26]; fn = w[5:0];
      rsn = w[25:21]; rtn = w[20:16]; rdn = w[15:11]; sh = w[10:6];
      a = regs[rsn]; b = regs[rtn];
      simm = {{16{w[15]}}, w[15:0]};
      zimm = {16'h0, w[15:0]};
      pc4 = pc + 32'd4;
      addr = a + simm;
      nxt = pc4;
      size = 0;
      if (op == OP_SPECIAL) begin
        case (fn)
          FN_SLL:  put_reg(rdn, b << sh);
          FN_SRL:  put_reg(rdn, b >> sh);
          FN_SRA:  put_reg(rdn, 32'($signed(b) >>> sh));
          FN_JR:   nxt = a;
          FN_MFHI: put_reg(rdn, hi);
          FN_MFLO: put_reg(rdn, lo);
          FN_MULT: begin
            sa = longint'($signed(a));
            sb2 = longint'($signed(b));
            p = sa * sb2;
            hi = p[63:32];
            lo = p[31:0];
          end
          FN_DIV: begin
            if (b == 0) begin
              lo = 32'hffff_ffff;
              hi = a;
            end else begin
              ms = a[31] ? -a : a;
              mt = b[31] ? -b : b;
              q = ms / mt;
              r = ms % mt;
              lo = (a[31] != b[31]) ? -q : q;
              hi = a[31] ? -r : r;
            end
          end
          FN_ADD:  put_reg(rdn, a + b);
          FN_SUB:  put_reg(rdn, a - b);
          FN_AND:  put_reg(rdn, a & b);
          FN_OR:   put_reg(rdn, a | b);
          FN_SLT:  put_reg(rdn, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
          default: return ST_FUNCT;
        endcase
        pc = nxt;
        return ST_OK;
      end
      case (op)
        OP_LB, OP_SB: size = 1;
        OP_LH, OP_SH: size = 2;
        OP_LW, OP_SW: size = 4;
        default: size = 0;
      endcase
      // every byte of the access has to sit inside the data window
      if (size != 0 && (addr < WIN_BASE ||
          longint'(addr - WIN_BASE) + size > longint'(DATA_BYTES)))
        return ST_ADDR;
      case (op)
        OP_J: nxt = {pc4[31:28], w[25:0], 2'b00};
        OP_JAL: begin
          put_reg(LR_IDX, pc4);
          nxt = {pc4[31:28], w[25:0], 2'b00};
        end
        OP_BEQ: if (a == b) nxt = pc4 + (simm << 2);
        OP_BNE: if (a != b) nxt = pc4 + (simm << 2);
        OP_ADDI, OP_ADDIU: put_reg(rtn, a + simm);
        OP_SLTI: put_reg(rtn, ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0);
        OP_ANDI: put_reg(rtn, a & zimm);
        OP_ORI:  put_reg(rtn, a | zimm);
        OP_LUI:  put_reg(rtn, zimm << 16);
        OP_LB: begin
          v = mem_get(addr, 1);
          put_reg(rtn, {{24{v[7]}}, v[7:0]});
        end
        OP_LH: begin
          v = mem_get(addr, 2);
          put_reg(rtn, {{16{v[15]}}, v[15:0]});
        end
        OP_LW: put_reg(rtn, mem_get(addr, 4));
        OP_SB, OP_SH, OP_SW: begin
          base = int'(addr - WIN_BASE);
          for (int i = 0; i < size; i++) dmem[base + i] = 8'(b >> (8 * i));
        end
        default: ;
      endcase
      pc = nxt;
      return ST_OK;
    endfunction

    function void set_config(logic idx, logic [31:0] val);
      if (idx == REG_PEND) prog_end = val[12:0];
      else floor = val;
    endfunction

    // accepted input: advance the state and queue the outcome
    function void note_input(item_t it);
      outcome_t o;
      o.status = ST_OK;
      o.read_value = 32'h0;
      if (it.kind == K_EXEC) begin
        if (halted) o.status = ST_HALT;
        else if (pc > TEXT_LIMIT || pc >= {19'h0, prog_end}) begin
          o.status = ST_HALT;
          halted = 1'b1;
        end else if (regs[SP_IDX] < floor) begin
          o.status = ST_STACK;
          halted = 1'b1;
        end else begin
          o.status = run_word(it.instr_word);
          if (o.status != ST_OK) halted = 1'b1;
        end
      end else begin
        if (it.kind == K_PRELOAD) dmem[it.mem_offset] = it.load_byte;
        else if (it.kind == K_READ) o.read_value = regs[it.reg_select];
        o.status = halted ? ST_HALT : ST_OK;
      end
      o.next_pc = pc;
      owed.push_back(o);
    endfunction

    task check_result(logic [2:0] st, logic [31:0] npc, logic [31:0] rv);
      outcome_t o;
      if (owed.size() == 0) begin
        report("unexpected result status", 32'(st), 32'h0);
        return;
      end
      o = owed.pop_front();
      if (st !== o.status) report("status", 32'(st), 32'(o.status));
      if (npc !== o.next_pc) report("next_pc", npc, o.next_pc);
      if (rv !== o.read_value) report("read_value", rv, o.read_value);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_kind;
  logic [31:0] in_instr_word;
  logic [11:0] in_mem_offset;
  logic [7:0]  in_load_byte;
  logic [4:0]  in_reg_select;
  logic        out_valid, out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_next_pc, out_read_value;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  exec_scoreboard sb = new();
  bit no_idle = 1'b0;  // stretches with both sides always ready
  int rx_left = 0;

  mips_subset_executor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_instr_word(in_instr_word), .in_mem_offset(in_mem_offset),
    .in_load_byte(in_load_byte), .in_reg_select(in_reg_select),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_next_pc(out_next_pc), .out_read_value(out_read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls in random stretches
  always @(posedge clk) begin
    if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (no_idle || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      rx_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b0;
      rx_left <= idle_len();
    end
  end

  // every result transfer is checked against the oldest outcome
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_next_pc, out_read_value);
  end

  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sh, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] jtype(logic [5:0] op, logic [25:0] idx);
    return {op, idx};
  endfunction

  // any register but the stack pointer, so the stack check stays quiet
  function automatic logic [4:0] dest_reg();
    logic [4:0] r;
    r = 5'($urandom_range(0, 31));
    if (r == SP_IDX) r = 5'd30;
    return r;
  endfunction

  // one instruction, mostly from the supported set, that keeps pc inside the text image
  function automatic logic [31:0] gen_word();
    logic [5:0]  alu_fn[8]  = '{FN_SLL, FN_SRL, FN_SRA, FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};
    logic [5:0]  imm_op[6]  = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_LUI};
    logic [5:0]  mem_op[6]  = '{OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW};
    logic [5:0]  md_fn[4]   = '{FN_MULT, FN_DIV, FN_MFHI, FN_MFLO};
    logic [5:0]  op;
    logic [4:0]  rs, rt;
    logic [31:0] tgt;
    int          lim, sel, size, idx, off;
    longint      diff;
    lim = (sb.prog_end > 13'h1000) ? 4096 : int'(sb.prog_end);
    if (int'(sb.pc) + 4 >= lim) return jtype(OP_J, 26'($urandom_range(0, (lim - 4) / 4)));
    sel = $urandom_range(0, 99);
    rs = 5'($urandom_range(0, 31));
    rt = 5'($urandom_range(0, 31));
    idx = $urandom_range(0, (lim - 4) / 4);
    if (sel < 25)
      return rtype(rs, rt, dest_reg(), 5'($urandom), alu_fn[$urandom_range(0, 7)]);
    if (sel < 45)
      return itype(imm_op[$urandom_range(0, 5)], rs, dest_reg(), 16'($urandom));
    if (sel < 70) begin
      op = mem_op[$urandom_range(0, 5)];
      size = (op == OP_LB || op == OP_SB) ? 1 : (op == OP_LH || op == OP_SH) ? 2 : 4;
      case ($urandom_range(0, 9))
        0: tgt = WIN_BASE;
        1: tgt = WIN_BASE + DATA_BYTES - size;  // last bytes of the window
        default: tgt = WIN_BASE + $urandom_range(0, DATA_BYTES - size);
      endcase
      diff = longint'(tgt) - longint'(sb.regs[rs]);
      if (diff < -32768 || diff > 32767) begin
        rs = 5'd0;
        diff = longint'(tgt);
      end
      if (op == OP_LB || op == OP_LH || op == OP_LW) rt = dest_reg();
      return itype(op, rs, rt, 16'(diff));
    end
    if (sel < 80) begin
      if ($urandom_range(0, 7) == 0) rt = 5'd0;  // divide by zero
      return rtype(rs, rt, dest_reg(), 5'd0, md_fn[$urandom_range(0, 3)]);
    end
    if (sel < 95) begin
      case ($urandom_range(0, 4))
        0: return jtype(OP_J, 26'(idx));
        1: return jtype(OP_JAL, 26'(idx));
        2, 3: begin
          if ($urandom_range(0, 1) == 1) rt = rs;
          off = (idx * 4 - (int'(sb.pc) + 4)) / 4;
          return itype(($urandom_range(0, 1) == 1) ? OP_BEQ : OP_BNE, rs, rt, 16'(off));
        end
        default: begin
          if (sb.regs[LR_IDX] < 32'(lim) && sb.regs[LR_IDX][1:0] == 2'b00)
            return rtype(LR_IDX, rt, dest_reg(), 5'd0, FN_JR);
          return jtype(OP_J, 26'(idx));
        end
      endcase
    end
    // opcode outside the set, pc just moves on
    forever begin
      op = 6'($urandom_range(1, 63));
      case (op)
        OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI,
        OP_LUI, OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW: ;
        default: return {op, 26'($urandom)};
      endcase
    end
  endfunction

  // one input transfer, then an optional gap; valid stays up when there is none
  task automatic send(logic [1:0] kind, logic [31:0] w);
    item_t it;
    it.kind = kind;
    it.instr_word = w;
    it.mem_offset = 12'($urandom);
    it.load_byte = 8'($urandom);
    it.reg_select = 5'($urandom);
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_instr_word <= it.instr_word;
    in_mem_offset <= it.mem_offset;
    in_load_byte <= it.load_byte;
    in_reg_select <= it.reg_select;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    if (idle_len() > 0) begin
      in_valid <= 1'b0;
      repeat (idle_len() + 1) @(posedge clk);
    end
  endtask

  task automatic exec(logic [31:0] w);
    send(K_EXEC, w);
  endtask

  task automatic send_preload(logic [11:0] offs, logic [7:0] val);
    item_t it;
    it = '{kind: K_PRELOAD, instr_word: 32'($urandom), mem_offset: offs,
           load_byte: val, reg_select: 5'($urandom)};
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_instr_word <= it.instr_word;
    in_mem_offset <= it.mem_offset;
    in_load_byte <= it.load_byte;
    in_reg_select <= it.reg_select;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic read_reg(logic [4:0] r);
    item_t it;
    it = '{kind: K_READ, instr_word: 32'($urandom), mem_offset: 12'($urandom),
           load_byte: 8'($urandom), reg_select: r};
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_instr_word <= it.instr_word;
    in_mem_offset <= it.mem_offset;
    in_load_byte <= it.load_byte;
    in_reg_select <= it.reg_select;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // block idle: nothing owed and any trailing work done
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // setup cycle then access cycle, the register takes the value on the access edge
  task automatic cfg_write(logic idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_config(idx, val);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) exec(gen_word());
    else if (r < 87) send(K_PRELOAD, 32'($urandom));
    else if (r < 97) send(K_READ, 32'($urandom));
    else send(2'd3, 32'($urandom));  // unused kind
  endtask

  initial begin
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = K_EXEC;
    in_instr_word = 0;
    in_mem_offset = 0;
    in_load_byte = 0;
    in_reg_select = 0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 0;
    pwdata = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, sign extension, window edges and a selection of functs and opcodes
    send_preload(12'h000, 8'h80);
    send_preload(12'hfff, 8'hff);
    read_reg(5'd0);
    read_reg(GP_IDX);
    read_reg(SP_IDX);
    exec(itype(OP_LB, 5'd0, 5'd1, 16'h2000));
    exec(itype(OP_LH, GP_IDX, 5'd2, 16'h17fe));       // straddles into the top byte
    exec(itype(OP_SW, SP_IDX, 5'd1, 16'hf000));        // last word of the window
    exec(itype(OP_LW, 5'd0, 5'd3, 16'h2ffc));
    exec(itype(OP_LUI, 5'd0, 5'd4, 16'h8000));
    exec(itype(OP_ADDI, 5'd0, 5'd5, 16'hffff));
    exec(rtype(5'd4, 5'd5, 5'd0, 5'd0, FN_DIV));       // most negative by minus one
    exec(rtype(5'd0, 5'd0, 5'd6, 5'd0, FN_MFLO));
    exec(rtype(5'd0, 5'd0, 5'd7, 5'd0, FN_MFHI));
    exec(rtype(5'd4, 5'd0, 5'd0, 5'd0, FN_DIV));       // divide by zero
    exec(rtype(5'd4, 5'd5, 5'd0, 5'd0, FN_MULT));
    exec(rtype(5'd0, 5'd4, 5'd8, 5'd31, FN_SRA));
    exec(rtype(5'd0, 5'd4, 5'd9, 5'd31, FN_SRL));
    exec(rtype(5'd0, 5'd5, 5'd0, 5'd4, FN_SLL));        // write to r0 is dropped
    exec(rtype(5'd4, 5'd4, 5'd10, 5'd0, FN_ADD));      // wraps
    exec(rtype(5'd4, 5'd5, 5'd11, 5'd0, FN_SLT));
    exec(itype(OP_SLTI, 5'd4, 5'd12, 16'h7fff));
    exec(itype(OP_BEQ, 5'd0, 5'd0, 16'h0001));
    exec(jtype(OP_JAL, 26'h10));
    exec(rtype(LR_IDX, 5'd0, 5'd0, 5'd0, FN_JR));
    exec(32'hfc00_0000);                               // unknown opcode
    send(2'd3, 32'h0);
    drain();

    // random phases with different limits, one of them with no idling at all
    for (int ph = 0; ph < 4; ph++) begin
      exec(jtype(OP_J, 26'h0));
      drain();
      case (ph)
        0: begin cfg_write(REG_PEND, 32'd4096); cfg_write(REG_FLOOR, 32'h0); end
        1: begin
          cfg_write(REG_PEND, $urandom_range(64, 4095));
          cfg_write(REG_FLOOR, $urandom_range(0, SP_RESET));
        end
        2: begin cfg_write(REG_PEND, 32'd256); cfg_write(REG_FLOOR, SP_RESET); end
        default: begin cfg_write(REG_PEND, 32'd4096); cfg_write(REG_FLOOR, FLOOR_RESET); end
      endcase
      no_idle = (ph == 2);
      for (int n = 0; n < 120; n++) random_item();
      no_idle = 1'b0;
    end
    drain();

    // one stopping error per run, then the stopped block
    pick = $urandom_range(0, 3);
    case (pick)
      0: cfg_write(REG_PEND, 32'd0);
      1: cfg_write(REG_FLOOR, 32'hffff_ffff);
      default: ;
    endcase
    if (pick == 2) exec(rtype(5'd1, 5'd2, 5'd3, 5'd0, 6'h01));
    else if (pick == 3) exec(itype(OP_LW, 5'd0, 5'd1, 16'h2ffd));
    else exec(gen_word());
    exec(gen_word());
    send(K_PRELOAD, 32'h0);
    read_reg(LR_IDX);
    send(2'd3, 32'h0);
    drain();
    cfg_write(REG_PEND, 32'd0);
    cfg_write(REG_FLOOR, 32'hffff_ffff);
    exec(32'h0);
    read_reg(GP_IDX);
    drain();

    if (sb.owed.size() != 0) sb.report("outcomes left over", 32'(sb.owed.size()), 32'h0);
    if (sb.errors == 0) begin
      $display("mips_subset_executor verification clean");
    end else begin
      $display("mips_subset_executor verification failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("mips_subset_executor verification failed");
    $finish;
  end

endmodule
